>>> rtl/core/tcce_pkg.sv
`timescale 1ns / 1ps

package tcce_pkg;

    // field widths fixed by the item format
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam int TAB_STEP = 8;

    // request types
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // control characters
    localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;

    localparam logic [ATTR_W-1:0] TEXT_COLOR_RST = 8'd15;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } req_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row_out;
        logic [COL_W-1:0]  cursor_col_out;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_color;
        logic              scrolled;
    } rsp_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_RD_WAIT,
        S_BS_RD,
        S_BS_CHK,
        S_BS_WR,
        S_NL_FILL,
        S_SCR_COPY,
        S_SCR_BLANK,
        S_CLR,
        S_DONE
    } state_t;

endpackage

>>> rtl/core/tcce_cell_ram.sv
`timescale 1ns / 1ps

module tcce_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [tcce_pkg::CELL_W-1:0]  wdata,
    input  logic [AW-1:0]                raddr,
    output logic [tcce_pkg::CELL_W-1:0]  rdata
);

    logic [tcce_pkg::CELL_W-1:0] mem [0:DEPTH-1];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/text_console_character_engine.sv
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req       in         req_valid / req_ready  tcce_pkg::req_t
// rsp       out        rsp_valid / rsp_ready  tcce_pkg::rsp_t
// cfg       in         cfg_we                 cfg_wdata (text colour)
//
// one item at a time; a plain put passes through S_DONE, a read through S_RD_WAIT and then S_DONE
// newline blanks one cell per cycle; backspace walks back through S_BS_RD and S_BS_CHK per cell walked
// scroll and clear write one screen cell per cycle (single ram write port)
// after reset a clearing pass zeroes all SCREEN_COLUMNS*SCREEN_LINES cells of the ram
// req_ready is low during that pass; cfg writes are taken at any time
// a finished result waits in the output register while the next item is taken

module text_console_character_engine #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_LINES   = 25
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  tcce_pkg::req_t        req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output tcce_pkg::rsp_t        rsp,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata
);

    localparam int CELLS = SCREEN_COLUMNS * SCREEN_LINES;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = AW + 1;

    localparam logic [tcce_pkg::COL_W-1:0] LAST_COL = tcce_pkg::COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [tcce_pkg::ROW_W-1:0] LAST_ROW = tcce_pkg::ROW_W'(SCREEN_LINES - 1);
    localparam logic [CW-1:0]              CNT_LAST = CW'(CELLS - 1);
    localparam logic [CW-1:0]              CNT_END  = CW'(CELLS);
    localparam logic [CW-1:0]              CNT_ROW1 = CW'(SCREEN_COLUMNS);
    localparam logic [CW-1:0]              CNT_BOT  = CW'(CELLS - SCREEN_COLUMNS);

    // control state
    tcce_pkg::state_t state_reg, state_next;
    logic [tcce_pkg::ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [tcce_pkg::COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [7:0]                  text_color_reg;
    logic                        rsp_valid_reg, rsp_valid_next;
    logic                        pend_reg, pend_next;

    // working registers
    logic [AW-1:0]               addr_reg, addr_next;
    logic [AW-1:0]               dst_reg, dst_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [7:0]                  res_char_reg, res_char_next;
    logic [7:0]                  res_color_reg, res_color_next;
    logic                        scrolled_reg, scrolled_next;
    tcce_pkg::rsp_t              rsp_reg, rsp_next;

    // ram port
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [tcce_pkg::CELL_W-1:0]  ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [tcce_pkg::CELL_W-1:0]  ram_rdata;

    logic [AW-1:0]                cur_addr;
    logic [AW-1:0]                rd_addr;
    logic                         rd_in_range;
    logic [7:0]                   tab_col;
    logic [tcce_pkg::CELL_W-1:0]  blank;
    logic                         req_take;

    tcce_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // linear cell addresses: row-major, constant multiply
    assign cur_addr = AW'(int'(cur_row_reg) * SCREEN_COLUMNS + int'(cur_col_reg));
    assign rd_addr  = AW'(int'(req.read_row) * SCREEN_COLUMNS + int'(req.read_col));

    assign rd_in_range = ({1'b0, req.read_row} < 6'(SCREEN_LINES)) &&
                         ({1'b0, req.read_col} < 8'(SCREEN_COLUMNS));

    assign tab_col  = {1'b0, cur_col_reg} + 8'(tcce_pkg::TAB_STEP);
    assign blank    = {text_color_reg, tcce_pkg::CH_NUL};

    assign req_ready = (state_reg == tcce_pkg::S_IDLE);
    assign req_take  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= tcce_pkg::TEXT_COLOR_RST;
        end
        else if (cfg_we)
        begin
            text_color_reg <= cfg_wdata;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcce_pkg::S_INIT;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            rsp_valid_reg <= rsp_valid_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        dst_reg       <= dst_next;
        res_char_reg  <= res_char_next;
        res_color_reg <= res_color_next;
        scrolled_reg  <= scrolled_next;
        rsp_reg       <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        pend_next      = 1'b0;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        dst_next       = dst_reg;
        res_char_next  = res_char_reg;
        res_color_next = res_color_reg;
        scrolled_next  = scrolled_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ram_we         = 1'b0;
        ram_waddr      = cur_addr;
        ram_wdata      = blank;
        ram_raddr      = addr_reg;

        case (state_reg)
            // zero every cell after reset
            tcce_pkg::S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = '0;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = tcce_pkg::S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            tcce_pkg::S_IDLE:
            begin
                if (req_take)
                begin
                    res_char_next  = '0;
                    res_color_next = '0;
                    scrolled_next  = 1'b0;
                    state_next     = tcce_pkg::S_DONE;
                    case (req.req_type)
                        tcce_pkg::REQ_PUT:
                        begin
                            case (req.char_code)
                                tcce_pkg::CH_NUL:
                                begin
                                    state_next = tcce_pkg::S_DONE;
                                end
                                tcce_pkg::CH_BS:
                                begin
                                    addr_next = cur_addr - AW'(1);
                                    if (cur_col_reg != '0)
                                    begin
                                        cur_col_next = cur_col_reg - tcce_pkg::COL_W'(1);
                                        state_next   = tcce_pkg::S_BS_WR;
                                    end
                                    else if (cur_row_reg != '0)
                                    begin
                                        // wrap to the row above, then walk back
                                        cur_row_next = cur_row_reg - tcce_pkg::ROW_W'(1);
                                        cur_col_next = LAST_COL;
                                        state_next   = tcce_pkg::S_BS_RD;
                                    end
                                    else
                                    begin
                                        addr_next  = cur_addr;
                                        state_next = tcce_pkg::S_BS_WR;
                                    end
                                end
                                tcce_pkg::CH_TAB:
                                begin
                                    if (tab_col >= 8'(SCREEN_COLUMNS))
                                    begin
                                        cur_col_next = '0;
                                    end
                                    else
                                    begin
                                        cur_col_next = tab_col[tcce_pkg::COL_W-1:0];
                                    end
                                end
                                tcce_pkg::CH_LF:
                                begin
                                    addr_next  = cur_addr;
                                    state_next = tcce_pkg::S_NL_FILL;
                                end
                                default:
                                begin
                                    // printable: write the cell and advance
                                    ram_we    = 1'b1;
                                    ram_wdata = {text_color_reg, req.char_code};
                                    if (cur_col_reg == LAST_COL)
                                    begin
                                        cur_col_next = '0;
                                        if (cur_row_reg == LAST_ROW)
                                        begin
                                            scrolled_next = 1'b1;
                                            cnt_next      = CNT_ROW1;
                                            state_next    = tcce_pkg::S_SCR_COPY;
                                        end
                                        else
                                        begin
                                            cur_row_next = cur_row_reg + tcce_pkg::ROW_W'(1);
                                        end
                                    end
                                    else
                                    begin
                                        cur_col_next = cur_col_reg + tcce_pkg::COL_W'(1);
                                    end
                                end
                            endcase
                        end
                        tcce_pkg::REQ_READ:
                        begin
                            if (rd_in_range)
                            begin
                                ram_raddr  = rd_addr;
                                state_next = tcce_pkg::S_RD_WAIT;
                            end
                        end
                        tcce_pkg::REQ_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = tcce_pkg::S_CLR;
                        end
                        default:
                        begin
                            state_next = tcce_pkg::S_DONE;
                        end
                    endcase
                end
            end

            tcce_pkg::S_RD_WAIT:
            begin
                res_char_next  = ram_rdata[7:0];
                res_color_next = ram_rdata[15:8];
                state_next     = tcce_pkg::S_DONE;
            end

            // backspace walk: read, then test the character byte
            tcce_pkg::S_BS_RD:
            begin
                ram_raddr  = addr_reg;
                state_next = tcce_pkg::S_BS_CHK;
            end

            tcce_pkg::S_BS_CHK:
            begin
                if ((ram_rdata[7:0] == tcce_pkg::CH_NUL) &&
                    ((cur_row_reg != '0) || (cur_col_reg != '0)))
                begin
                    addr_next = addr_reg - AW'(1);
                    if (cur_col_reg != '0)
                    begin
                        cur_col_next = cur_col_reg - tcce_pkg::COL_W'(1);
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg - tcce_pkg::ROW_W'(1);
                        cur_col_next = LAST_COL;
                    end
                    state_next = tcce_pkg::S_BS_RD;
                end
                else
                begin
                    state_next = tcce_pkg::S_BS_WR;
                end
            end

            tcce_pkg::S_BS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = addr_reg;
                state_next = tcce_pkg::S_DONE;
            end

            // newline: blank to end of row, then next row or scroll
            tcce_pkg::S_NL_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                addr_next = addr_reg + AW'(1);
                if (cur_col_reg == LAST_COL)
                begin
                    cur_col_next = '0;
                    if (cur_row_reg == LAST_ROW)
                    begin
                        scrolled_next = 1'b1;
                        cnt_next      = CNT_ROW1;
                        state_next    = tcce_pkg::S_SCR_COPY;
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg + tcce_pkg::ROW_W'(1);
                        state_next   = tcce_pkg::S_DONE;
                    end
                end
                else
                begin
                    cur_col_next = cur_col_reg + tcce_pkg::COL_W'(1);
                end
            end

            // scroll copy: read cell k, write it one row up in the following cycle
            tcce_pkg::S_SCR_COPY:
            begin
                ram_waddr = dst_reg;
                ram_wdata = ram_rdata;
                ram_we    = pend_reg;
                if (cnt_reg != CNT_END)
                begin
                    ram_raddr = cnt_reg[AW-1:0];
                    dst_next  = AW'(cnt_reg - CNT_ROW1);
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    cnt_next   = CNT_BOT;
                    state_next = tcce_pkg::S_SCR_BLANK;
                end
            end

            tcce_pkg::S_SCR_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = tcce_pkg::S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            tcce_pkg::S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = tcce_pkg::S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            // hand the result over once the output register is free
            tcce_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.cursor_row_out = cur_row_reg;
                    rsp_next.cursor_col_out = cur_col_reg;
                    rsp_next.cell_char      = res_char_reg;
                    rsp_next.cell_color     = res_color_reg;
                    rsp_next.scrolled       = scrolled_reg;
                    rsp_valid_next          = 1'b1;
                    state_next              = tcce_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tcce_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // an accepted item always starts work, so ready is low in the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> !req_ready)
        else $error("req_ready still high after an item was taken");

    // cursor never leaves the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_col_reg <= LAST_COL) && (cur_row_reg <= LAST_ROW))
        else $error("cursor outside the screen");

    // a scroll always leaves the cursor on the bottom row
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcce_pkg::S_DONE) && scrolled_reg |-> cur_row_reg == LAST_ROW)
        else $error("scroll finished with cursor off the bottom row");

    // ram writes stay inside the cell array
    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CW'(ram_waddr) < CNT_END))
        else $error("ram write beyond the last cell");
`endif

endmodule
